// ===== hw/rtl/sha512_pkg.sv =====
// shared types, constants and round functions for the sha-512 / sha-384 engine
// no dependencies; imported by every module of the block
package sha512_pkg;

  localparam int unsigned WordW     = 64;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds    = 80;

  typedef logic [WordW-1:0] word_t;

  // one padded block word moving from the front to the back
  typedef struct packed {
    word_t word;
    logic  fin;  // last word of the final block of a message
  } blk_word_t;

  localparam word_t Iv512 [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam word_t Iv384 [8] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };

  localparam word_t RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic word_t big_sigma0(word_t x);
    return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
  endfunction

  function automatic word_t big_sigma1(word_t x);
    return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
  endfunction

  function automatic word_t small_sigma0(word_t x);
    return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ {7'd0, x[63:7]};
  endfunction

  function automatic word_t small_sigma1(word_t x);
    return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ {6'd0, x[63:6]};
  endfunction

endpackage

// ===== hw/rtl/sha512_front.sv =====
// front end: takes message words, counts bytes, pads and appends the bit length
// emits padded block words into the queue; uses sha512_pkg
module sha512_front import sha512_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        clear_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] message_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_in_message_i,
  input  logic        full_i,
  output logic        push_o,
  output blk_word_t   push_data_o
);

  localparam logic [2:0] FIdle  = 3'd0;
  localparam logic [2:0] FExtra = 3'd1;
  localparam logic [2:0] FZero  = 3'd2;
  localparam logic [2:0] FLenHi = 3'd3;
  localparam logic [2:0] FLenLo = 3'd4;

  localparam logic [3:0] LenPos = 4'd14;

  logic [2:0]   state_q, state_d;
  logic [3:0]   fill_q, fill_d;
  logic [127:0] bytes_q, bytes_d;
  logic [3:0]   nbytes;
  word_t        padded;
  logic [127:0] bits;
  logic [3:0]   fill_inc;

  assign nbytes   = (byte_count_i > 4'd8) ? 4'd8 : byte_count_i;
  assign bits     = {bytes_q[124:0], 3'b000};
  assign fill_inc = fill_q + 4'd1;

  // keep the valid bytes, put the 0x80 marker right behind them
  always_comb begin
    padded = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < nbytes) begin
        padded[63-8*b -: 8] = message_word_i[63-8*b -: 8];
      end else if (4'(b) == nbytes) begin
        padded[63-8*b -: 8] = 8'h80;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    bytes_d     = bytes_q;
    push_o      = 1'b0;
    push_data_o = '{word: '0, fin: 1'b0};
    in_ready_o  = 1'b0;
    case (state_q)
      FIdle: begin
        in_ready_o = !full_i;
        if (in_valid_i && !full_i) begin
          push_o = 1'b1;
          fill_d = fill_inc;
          if (!last_in_message_i) begin
            push_data_o.word = message_word_i;
            bytes_d = bytes_q + 128'd8;
          end else begin
            bytes_d = bytes_q + {124'd0, nbytes};
            if (nbytes == 4'd8) begin
              push_data_o.word = message_word_i;
              state_d = FExtra;
            end else begin
              push_data_o.word = padded;
              state_d = (fill_inc == LenPos) ? FLenHi : FZero;
            end
          end
        end
      end
      FExtra: begin
        if (!full_i) begin
          push_o = 1'b1;
          push_data_o.word = {8'h80, 56'd0};
          fill_d = fill_inc;
          state_d = (fill_inc == LenPos) ? FLenHi : FZero;
        end
      end
      FZero: begin
        if (!full_i) begin
          push_o = 1'b1;
          fill_d = fill_inc;
          if (fill_inc == LenPos) begin
            state_d = FLenHi;
          end
        end
      end
      FLenHi: begin
        if (!full_i) begin
          push_o = 1'b1;
          push_data_o.word = bits[127:64];
          fill_d = fill_inc;
          state_d = FLenLo;
        end
      end
      FLenLo: begin
        if (!full_i) begin
          push_o = 1'b1;
          push_data_o.word = bits[63:0];
          push_data_o.fin = 1'b1;
          fill_d = '0;
          bytes_d = '0;
          state_d = FIdle;
        end
      end
      default: begin
        state_d = FIdle;
      end
    endcase
    if (clear_i) begin
      state_d = FIdle;
      fill_d  = '0;
      bytes_d = '0;
      push_o  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
      fill_q  <= '0;
      bytes_q <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bytes_q <= bytes_d;
    end
  end

endmodule

// ===== hw/rtl/sha512_queue.sv =====
// short first-in first-out queue of padded block words between front and back
// uses sha512_pkg for the entry type
module sha512_queue import sha512_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      clear_i,
  input  logic      push_i,
  input  blk_word_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output blk_word_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  blk_word_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else if (clear_i) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

// ===== hw/rtl/sha512_back.sv =====
// back end: loads 16 block words, runs 80 compression rounds one per cycle,
// updates the hash state and hands out the digest words; uses sha512_pkg
module sha512_back import sha512_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        q_valid_i,
  input  blk_word_t   q_data_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        digest_last_o
);

  localparam logic [1:0] BLoad  = 2'd0;
  localparam logic [1:0] BRound = 2'd1;
  localparam logic [1:0] BAdd   = 2'd2;
  localparam logic [1:0] BOut   = 2'd3;

  localparam logic [6:0] LastRound = 7'(Rounds - 1);

  logic [1:0] state_q;
  logic [3:0] cnt_q;
  logic [6:0] rnd_q;
  logic [2:0] idx_q;
  logic       fin_q;
  logic       variant_q;
  word_t      sched_q [BlockWords];
  word_t      v_q [8];
  word_t      hash_q [8];

  word_t w_new, w_t, t1, t2, ch, maj;
  logic  last_idx;

  assign w_new = small_sigma1(sched_q[14]) + sched_q[9] + small_sigma0(sched_q[1]) + sched_q[0];
  assign w_t   = (rnd_q < 7'(BlockWords)) ? sched_q[0] : w_new;
  assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1    = v_q[7] + big_sigma1(v_q[4]) + ch + RoundK[rnd_q] + w_t;
  assign t2    = big_sigma0(v_q[0]) + maj;

  assign pop_o         = (state_q == BLoad) && q_valid_i;
  assign out_valid_o   = (state_q == BOut);
  assign digest_word_o = hash_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_idx      = variant_q ? (idx_q == 3'd5) : (idx_q == 3'd7);
  assign digest_last_o = last_idx;

  // message schedule and working variables, no reset needed
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        sched_q[i] <= sched_q[i+1];
      end
      sched_q[BlockWords-1] <= q_data_i.word;
    end else if (state_q == BRound) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        sched_q[i] <= sched_q[i+1];
      end
      sched_q[BlockWords-1] <= w_t;
    end
    if (pop_o && cnt_q == 4'd15) begin
      v_q <= hash_q;
    end else if (state_q == BRound) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BLoad;
      cnt_q     <= '0;
      rnd_q     <= '0;
      idx_q     <= '0;
      fin_q     <= 1'b0;
      variant_q <= 1'b0;
      hash_q    <= Iv512;
    end else if (cfg_we_i) begin
      state_q   <= BLoad;
      cnt_q     <= '0;
      rnd_q     <= '0;
      idx_q     <= '0;
      fin_q     <= 1'b0;
      variant_q <= cfg_wdata_i;
      hash_q    <= cfg_wdata_i ? Iv384 : Iv512;
    end else begin
      case (state_q)
        BLoad: begin
          if (q_valid_i) begin
            cnt_q <= cnt_q + 4'd1;
            if (cnt_q == 4'd15) begin
              fin_q   <= q_data_i.fin;
              rnd_q   <= '0;
              state_q <= BRound;
            end
          end
        end
        BRound: begin
          rnd_q <= rnd_q + 7'd1;
          if (rnd_q == LastRound) begin
            state_q <= BAdd;
          end
        end
        BAdd: begin
          for (int i = 0; i < 8; i++) begin
            hash_q[i] <= hash_q[i] + v_q[i];
          end
          idx_q   <= '0;
          state_q <= fin_q ? BOut : BLoad;
        end
        BOut: begin
          if (out_ready_i) begin
            idx_q <= idx_q + 3'd1;
            if (last_idx) begin
              hash_q  <= variant_q ? Iv384 : Iv512;
              state_q <= BLoad;
            end
          end
        end
        default: begin
          state_q <= BLoad;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/sha512_hash_engine_top.sv =====
// SHA-512 / SHA-384 engine. Message words enter big-endian with valid/ready; the
// front pads and counts bytes and feeds a short queue; the back compresses each
// 1024-bit block one round per cycle over 80 rounds; the round state is loaded with
// the last of the 16 queue pops and a final add state folds it into the hash; the
// back pops no new block words while it runs the rounds and the add.
// The last word adds up to one extra block and then 8 digest words (6 for SHA-384)
// leave one per cycle while out_ready_i is high.
// A write of the variant register restarts the message with that variant's
// initial values. Depends on sha512_pkg and the front, queue and back modules.
module sha512_hash_engine_top import sha512_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] message_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_in_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        digest_last_o
);

  logic      push, full, pop, q_valid;
  blk_word_t push_data, pop_data;

  sha512_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .clear_i           (cfg_we_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .message_word_i    (message_word_i),
    .byte_count_i      (byte_count_i),
    .last_in_message_i (last_in_message_i),
    .full_i            (full),
    .push_o            (push),
    .push_data_o       (push_data)
  );

  sha512_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_we_i),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  sha512_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_valid_i     (q_valid),
    .q_data_i      (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .digest_last_o (digest_last_o)
  );

endmodule
